// ===== sv/aeoc_pkg.sv =====
`default_nettype none
package aeoc_pkg;

    localparam int AXES            = 3;
    localparam int AXIS_W          = $clog2(AXES);
    localparam int FRAC_BITS       = 8;
    localparam int MAX_CAL_SAMPLES = 1023;

    localparam int WORD_W  = 16;
    localparam int RAW_W   = 12;
    localparam int RAW_LSB = WORD_W - RAW_W;
    localparam int SMP_W   = RAW_W + FRAC_BITS;
    localparam int EMA_W   = 20;
    localparam int SUM_W   = 30;
    localparam int OFF_W   = 21;
    localparam int OUT_W   = 22;
    localparam int CNT_W   = 10;
    localparam int ALPHA_W = 3;
    localparam int GRAV_W  = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRAV  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 3'd2;
    localparam logic [CNT_W-1:0]   CAL_RST   = 10'd150;
    localparam logic [GRAV_W-1:0]  GRAV_RST  = 11'd512;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam int DIV_STEP_W = $clog2(SUM_W);

    // decoded sample of all three axes, axis 0 in the low slice
    typedef logic [AXES-1:0][SMP_W-1:0] t_item;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [CNT_W-1:0]   cal_samples;
        logic [GRAV_W-1:0]  gravity;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILT,
        BK_POST,
        BK_DIV_START,
        BK_DIV_WAIT
    } t_back_state;

endpackage
`default_nettype wire

// ===== sv/aeoc_in_if.sv =====
`default_nettype none
interface aeoc_in_if;
    import aeoc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] z_word;
    logic              read_ok;

    modport source (output valid, output x_word, output y_word, output z_word,
                    output read_ok, input ready);
    modport sink   (input valid, input x_word, input y_word, input z_word,
                    input read_ok, output ready);
endinterface
`default_nettype wire

// ===== sv/aeoc_out_if.sv =====
`default_nettype none
interface aeoc_out_if;
    import aeoc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    in_calibration;
    logic signed [OUT_W-1:0] x_calibrated;
    logic signed [OUT_W-1:0] y_calibrated;
    logic signed [OUT_W-1:0] z_calibrated;

    modport source (output valid, output in_calibration, output x_calibrated,
                    output y_calibrated, output z_calibrated, input ready);
    modport sink   (input valid, input in_calibration, input x_calibrated,
                    input y_calibrated, input z_calibrated, output ready);
endinterface
`default_nettype wire

// ===== sv/aeoc_front.sv =====
`default_nettype none
module aeoc_front (
    aeoc_in_if.sink         i_acc,
    input  logic            i_q_ready,
    output logic            o_push,
    output aeoc_pkg::t_item o_item
);
    import aeoc_pkg::*;

    logic [AXES-1:0][WORD_W-1:0] w_words;

    assign w_words = {i_acc.z_word, i_acc.y_word, i_acc.x_word};

    assign i_acc.ready = i_q_ready;
    assign o_push      = i_acc.valid & i_q_ready;

    // top 12 bits are already two's complement, append the fraction bits
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (i_acc.read_ok) begin
                o_item[a] = {w_words[a][WORD_W-1:RAW_LSB], {FRAC_BITS{1'b0}}};
            end else begin
                o_item[a] = '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/aeoc_queue.sv =====
`default_nettype none
module aeoc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aeoc_pkg::t_item i_push_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output aeoc_pkg::t_item o_item
);
    import aeoc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/aeoc_div.sv =====
`default_nettype none
module aeoc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aeoc_pkg::t_div_req i_req,
    output aeoc_pkg::t_div_rsp o_rsp
);
    import aeoc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_den;
    logic [SUM_W-1:0]      r_quo;

    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;
    logic [CNT_W-1:0] n_rem;

    // restoring division, one quotient bit per cycle, msb first
    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= DIV_STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

endmodule
`default_nettype wire

// ===== sv/aeoc_back.sv =====
`default_nettype none
module aeoc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aeoc_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  aeoc_pkg::t_item i_item,
    output logic            o_pop,
    aeoc_out_if.source      o_res
);
    import aeoc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic signed [SMP_W-1:0] r_smp [AXES];
    logic signed [EMA_W-1:0] r_ema [AXES];
    logic signed [SUM_W-1:0] r_sum [AXES];
    logic signed [OFF_W-1:0] r_off [AXES];
    logic [CNT_W-1:0]        r_count;
    logic                    r_cal;
    logic [AXIS_W-1:0]       r_axis;
    logic [GRAV_W-1:0]       r_grav;
    logic                    r_neg;

    logic                    r_out_valid;
    logic                    r_out_cal;
    logic signed [OUT_W-1:0] r_out_val [AXES];

    logic signed [EMA_W:0]   w_diff [AXES];
    logic signed [EMA_W:0]   w_step [AXES];
    logic signed [EMA_W:0]   w_upd  [AXES];
    logic signed [EMA_W-1:0] n_ema  [AXES];
    logic signed [SUM_W-1:0] n_sum  [AXES];
    logic signed [OUT_W-1:0] n_out  [AXES];
    logic [CNT_W-1:0]        n_count;
    logic                    w_first;
    logic                    w_cal_end;
    logic                    w_out_free;
    logic                    w_post_go;

    logic signed [SUM_W-1:0] w_sel_sum;
    logic [SUM_W-1:0]        w_mag;
    logic [OFF_W-1:0]        w_quo;
    logic [OFF_W-1:0]        w_sq;
    logic signed [OFF_W-1:0] n_off;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    aeoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_post_go  = (r_state == BK_POST) && w_out_free;

    // smoothing: first sample loads the average, else step by floor(diff / 2^k)
    always_comb begin
        w_first = (r_count == '0);
        for (int a = 0; a < AXES; a++) begin
            if (r_ema[a] != '0) begin
                w_first = 1'b0;
            end
        end
        for (int a = 0; a < AXES; a++) begin
            w_diff[a] = {r_smp[a][SMP_W-1], r_smp[a]} - {r_ema[a][EMA_W-1], r_ema[a]};
            w_step[a] = w_diff[a] >>> i_cfg.alpha;
            w_upd[a]  = {r_ema[a][EMA_W-1], r_ema[a]} + w_step[a];
            n_ema[a]  = w_first ? r_smp[a] : w_upd[a][EMA_W-1:0];
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a] + {{(SUM_W - EMA_W){r_ema[a][EMA_W-1]}}, r_ema[a]};
            n_out[a] = {{(OUT_W - EMA_W){r_ema[a][EMA_W-1]}}, r_ema[a]}
                     - {{(OUT_W - OFF_W){r_off[a][OFF_W-1]}}, r_off[a]};
        end
        n_count   = (r_count < CNT_W'(MAX_CAL_SAMPLES)) ? r_count + 1'b1 : r_count;
        w_cal_end = (n_count >= i_cfg.cal_samples);
    end

    // offset = trunc(sum / count), gravity taken off the z axis
    always_comb begin
        w_sel_sum = r_sum[r_axis];
        w_mag     = w_sel_sum[SUM_W-1] ? SUM_W'(-w_sel_sum) : SUM_W'(w_sel_sum);
        w_quo     = w_div_rsp.quotient[OFF_W-1:0];
        w_sq      = r_neg ? (~w_quo + 1'b1) : w_quo;
        if (r_axis == AXIS_Z) begin
            n_off = w_sq - OFF_W'({r_grav, {FRAC_BITS{1'b0}}});
        end else begin
            n_off = w_sq;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_FILT;
                end
            end
            BK_FILT: begin
                n_state = BK_POST;
            end
            BK_POST: begin
                if (w_out_free) begin
                    n_state = (r_cal && w_cal_end) ? BK_DIV_START : BK_IDLE;
                end
            end
            BK_DIV_START: begin
                n_state = BK_DIV_WAIT;
            end
            BK_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_axis == AXIS_Z) ? BK_IDLE : BK_DIV_START;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop              = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_mag;
        w_div_req.divisor  = r_count;
        case (r_state)
            BK_IDLE: begin
                o_pop = i_q_valid;
            end
            BK_DIV_START: begin
                w_div_req.start = 1'b1;
            end
            default: begin
                o_pop           = 1'b0;
                w_div_req.start = 1'b0;
            end
        endcase
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.in_calibration = r_out_cal;
    assign o_res.x_calibrated   = r_out_val[0];
    assign o_res.y_calibrated   = r_out_val[1];
    assign o_res.z_calibrated   = r_out_val[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cal       <= 1'b1;
            r_axis      <= AXIS_X;
            for (int a = 0; a < AXES; a++) begin
                r_ema[a] <= '0;
                r_sum[a] <= '0;
                r_off[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_post_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_FILT) begin
                for (int a = 0; a < AXES; a++) begin
                    r_ema[a] <= n_ema[a];
                end
            end
            if (w_post_go && r_cal) begin
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a] <= n_sum[a];
                end
                r_count <= n_count;
                if (w_cal_end) begin
                    r_cal  <= 1'b0;
                    r_axis <= AXIS_X;
                end
            end
            if ((r_state == BK_DIV_WAIT) && w_div_rsp.done) begin
                r_off[r_axis] <= n_off;
                if (r_axis != AXIS_Z) begin
                    r_axis <= r_axis + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int a = 0; a < AXES; a++) begin
                r_smp[a] <= i_item[a];
            end
        end
        // gravity is held so a register write during the divide cannot reach it
        if (w_post_go && r_cal && w_cal_end) begin
            r_grav <= i_cfg.gravity;
        end
        if (r_state == BK_DIV_START) begin
            r_neg <= w_sel_sum[SUM_W-1];
        end
        if (w_post_go) begin
            r_out_cal <= r_cal;
            for (int a = 0; a < AXES; a++) begin
                r_out_val[a] <= r_cal ? '0 : n_out[a];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/accel_ema_offset_calibrator.sv =====
// an accepted beat is queued, popped, filtered, and its result registered at the output step;
// the next beat is popped only after that step, which waits while the output is stalled
// the beat that ends calibration is followed by the three offsets, one axis at a time on
// the shared serial divider, before the next queued beat is taken
// reset (i_rst_n low at a clock edge) restores register defaults, clears averages,
// sums, offsets and sample count, and restarts calibration; no clearing pass
`default_nettype none
module accel_ema_offset_calibrator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    aeoc_in_if.sink                      i_acc,
    aeoc_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aeoc_pkg::APB_AW-1:0]  paddr,
    input  logic [aeoc_pkg::APB_DW-1:0]  pwdata,
    output logic [aeoc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import aeoc_pkg::*;

    logic [ALPHA_W-1:0]   r_alpha;
    logic [CNT_W-1:0]     r_cal_samples;
    logic [GRAV_W-1:0]    r_gravity;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;
    t_cfg                 w_cfg;

    logic  w_push;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_push_item;
    t_item w_q_item;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= ALPHA_RST;
            r_cal_samples <= CAL_RST;
            r_gravity     <= GRAV_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ALPHA: r_alpha       <= pwdata[ALPHA_W-1:0];
                REG_CAL:   r_cal_samples <= pwdata[CNT_W-1:0];
                REG_GRAV:  r_gravity     <= pwdata[GRAV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ALPHA: prdata = APB_DW'(r_alpha);
            REG_CAL:   prdata = APB_DW'(r_cal_samples);
            REG_GRAV:  prdata = APB_DW'(r_gravity);
            default:   prdata = '0;
        endcase
    end

    assign w_cfg.alpha       = r_alpha;
    assign w_cfg.cal_samples = r_cal_samples;
    assign w_cfg.gravity     = r_gravity;

    aeoc_front u_front (
        .i_acc     (i_acc),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    aeoc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_ready     (w_q_ready),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_item      (w_q_item)
    );

    aeoc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire
